[hdl/dphd_pkg.sv]
package dphd_pkg;

  // Field widths
  localparam int SAMPLE_BITS    = 12;
  localparam int TIME_BITS      = 32;
  localparam int RETRIG_BITS    = 20;
  localparam int SCAN_BITS      = 16;
  localparam int XTALK_BITS     = 20;
  localparam int CFG_DATA_BITS  = 20;
  localparam int CFG_INDEX_BITS = 3;

  // Head must beat rim by more than this to win
  localparam logic [SAMPLE_BITS:0] HEAD_MARGIN = (SAMPLE_BITS+1)'(100);

  typedef enum logic [1:0] {
    HIT_NONE = 2'd0,
    HIT_HEAD = 2'd1,
    HIT_RIM  = 2'd2
  } hit_kind_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LOW_HEAD  = 3'd0,
    CFG_LOW_RIM   = 3'd1,
    CFG_HIGH_HEAD = 3'd2,
    CFG_HIGH_RIM  = 3'd3,
    CFG_RETRIG    = 3'd4,
    CFG_SCAN      = 3'd5,
    CFG_XTALK     = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_head;
    logic [SAMPLE_BITS-1:0] sample_rim;
    logic [TIME_BITS-1:0]   time_now;
  } in_item_t;

  typedef struct packed {
    hit_kind_t              hit_kind;
    logic [SAMPLE_BITS-1:0] peak_head_out;
    logic [SAMPLE_BITS-1:0] peak_rim_out;
    logic [TIME_BITS-1:0]   hit_time;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] low_threshold_head;
    logic [SAMPLE_BITS-1:0] low_threshold_rim;
    logic [SAMPLE_BITS-1:0] high_threshold_head;
    logic [SAMPLE_BITS-1:0] high_threshold_rim;
    logic [RETRIG_BITS-1:0] retrigger_time;
    logic [SCAN_BITS-1:0]   scan_time;
    logic [XTALK_BITS-1:0]  crosstalk_time;
  } cfg_t;

endpackage

[hdl/dphd_cfg.sv]
module dphd_cfg
  import dphd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index; unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LOW_HEAD:  cfg_nxt.low_threshold_head  = cfg_data[SAMPLE_BITS-1:0];
        CFG_LOW_RIM:   cfg_nxt.low_threshold_rim   = cfg_data[SAMPLE_BITS-1:0];
        CFG_HIGH_HEAD: cfg_nxt.high_threshold_head = cfg_data[SAMPLE_BITS-1:0];
        CFG_HIGH_RIM:  cfg_nxt.high_threshold_rim  = cfg_data[SAMPLE_BITS-1:0];
        CFG_RETRIG:    cfg_nxt.retrigger_time      = cfg_data[RETRIG_BITS-1:0];
        CFG_SCAN:      cfg_nxt.scan_time           = cfg_data[SCAN_BITS-1:0];
        CFG_XTALK:     cfg_nxt.crosstalk_time      = cfg_data[XTALK_BITS-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/dphd_core.sv]
module dphd_core
  import dphd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      item_valid,
  input  in_item_t  item,
  output out_item_t res
);

  logic                   group_open_r, group_open_nxt;
  logic [TIME_BITS-1:0]   start_r, start_nxt;
  logic [SAMPLE_BITS-1:0] peak_head_r, peak_head_nxt;
  logic [SAMPLE_BITS-1:0] peak_rim_r, peak_rim_nxt;
  logic [TIME_BITS-1:0]   head_ref_r, head_ref_nxt;
  logic [TIME_BITS-1:0]   rim_ref_r, rim_ref_nxt;

  logic [TIME_BITS-1:0]   head_gap, rim_gap, elapsed, xtalk_ref;
  logic                   head_rdy, rim_rdy, opens, win_end;
  logic [SAMPLE_BITS-1:0] head_max, rim_max;
  logic                   head_ok, rim_ok, head_wins;

  // Readiness: signed distance from the hold-off reference
  assign head_gap = item.time_now - head_ref_r;
  assign rim_gap  = item.time_now - rim_ref_r;
  assign head_rdy = !head_gap[TIME_BITS-1] &&
                    (head_gap >= TIME_BITS'(cfg.retrigger_time));
  assign rim_rdy  = !rim_gap[TIME_BITS-1] &&
                    (rim_gap >= TIME_BITS'(cfg.retrigger_time));
  assign opens = ((item.sample_head >= cfg.low_threshold_head) && head_rdy) ||
                 ((item.sample_rim >= cfg.low_threshold_rim) && rim_rdy);

  // Running peaks and window end
  assign head_max = (item.sample_head > peak_head_r) ? item.sample_head : peak_head_r;
  assign rim_max  = (item.sample_rim > peak_rim_r) ? item.sample_rim : peak_rim_r;
  assign elapsed  = item.time_now - start_r;
  assign win_end  = elapsed >= TIME_BITS'(cfg.scan_time);

  // Hit classification
  assign head_ok   = head_max >= cfg.high_threshold_head;
  assign rim_ok    = rim_max >= cfg.high_threshold_rim;
  assign head_wins = head_ok &&
                     ({1'b0, head_max} > ({1'b0, rim_max} + HEAD_MARGIN));
  assign xtalk_ref = item.time_now + TIME_BITS'(cfg.crosstalk_time);

  always_comb begin
    group_open_nxt = group_open_r;
    start_nxt      = start_r;
    peak_head_nxt  = peak_head_r;
    peak_rim_nxt   = peak_rim_r;
    head_ref_nxt   = head_ref_r;
    rim_ref_nxt    = rim_ref_r;
    res.hit_kind      = HIT_NONE;
    res.peak_head_out = '0;
    res.peak_rim_out  = '0;
    res.hit_time      = item.time_now;
    if (!group_open_r) begin
      // Open a scan group and seed the peaks
      if (opens) begin
        group_open_nxt = 1'b1;
        start_nxt      = item.time_now;
        peak_head_nxt  = item.sample_head;
        peak_rim_nxt   = item.sample_rim;
      end
    end else begin
      peak_head_nxt = head_max;
      peak_rim_nxt  = rim_max;
      // Close the group; report the peaks of a valid group and restart hold-offs on a hit
      if (win_end) begin
        group_open_nxt = 1'b0;
        peak_head_nxt  = '0;
        peak_rim_nxt   = '0;
        if (head_ok || rim_ok) begin
          res.peak_head_out = head_max;
          res.peak_rim_out  = rim_max;
          if (head_wins) begin
            res.hit_kind = HIT_HEAD;
            head_ref_nxt = item.time_now;
            rim_ref_nxt  = xtalk_ref;
          end else if (rim_ok) begin
            res.hit_kind = HIT_RIM;
            rim_ref_nxt  = item.time_now;
            head_ref_nxt = xtalk_ref;
          end
        end
      end
    end
  end

  // Advance state only on a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_open_r <= 1'b0;
      start_r      <= '0;
      peak_head_r  <= '0;
      peak_rim_r   <= '0;
      head_ref_r   <= '0;
      rim_ref_r    <= '0;
    end else if (item_valid) begin
      group_open_r <= group_open_nxt;
      start_r      <= start_nxt;
      peak_head_r  <= peak_head_nxt;
      peak_rim_r   <= peak_rim_nxt;
      head_ref_r   <= head_ref_nxt;
      rim_ref_r    <= rim_ref_nxt;
    end
  end

endmodule

[hdl/dphd_skid.sv]
module dphd_skid
  import dphd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_stall,
  input  out_item_t up_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      up_take, main_free;

  assign up_stall  = skid_valid_r;
  assign up_take   = up_valid && !skid_valid_r;
  assign main_free = !main_valid_r || !out_stall;

  // Refill the output register from the skid stage first, else from the input; park in skid when it is busy
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (main_free) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = up_take;
        if (up_take) begin
          main_nxt = up_data;
        end
      end
    end else if (up_take) begin
      skid_nxt       = up_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

[hdl/drum_pad_hit_detector.sv]
// Drum pad hit detector: head and rim piezo trigger with peak capture.
// Input channel (in_valid / in_stall / in_data): one head sample, one rim
// sample and a microsecond timestamp per transfer.
// Result channel (out_valid / out_stall / out_data): exactly one result per
// input transfer, in order: hit kind, both peaks of a valid group and the
// echoed timestamp.
// Configuration port (cfg_wr_en / cfg_index / cfg_data): write thresholds
// and times while the block is idle; takes effect on the next item.
// Output: a result is registered in the result register, or in the skid
// register while the output stalls. Throughput: one item per cycle while
// in_stall is low; the detection logic ahead of them is combinational.
// Stall: a two-entry output stage (result register plus skid register) keeps
// accepting while one result waits; in_stall rises only when both hold data.
// Reset (rst_n low, synchronous) clears the configuration and detector state,
// the scan group and both pad hold-offs, and empties the output stage.
module drum_pad_hit_detector
  import dphd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t      cfg;
  out_item_t res;
  logic      in_take;

  assign in_take = in_valid && !in_stall;

  dphd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dphd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_take),
    .item       (in_data),
    .res        (res)
  );

  dphd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_stall  (in_stall),
    .up_data   (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hdl/dphd_checker.sv]
module dphd_checker
  import dphd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input out_item_t out_data,
  input logic      out_valid,
  input logic      out_stall
);

  // Output stage empties on reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output stage not empty after reset");

  // Input stalls only when a result is already waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // A waiting result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A head hit needs the head peak above the rim peak
  a_head_margin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.hit_kind == HIT_HEAD) |->
      (out_data.peak_head_out > out_data.peak_rim_out))
    else $error("head hit without head peak above rim peak");

endmodule

bind drum_pad_hit_detector dphd_checker u_dphd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

[tb/testbench.sv]
module testbench;
  import dphd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int LONG_HOLD = 90;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [SAMPLE_BITS:0] HEAD_LEAD = (SAMPLE_BITS+1)'(100);
  localparam int N_DIRECTED = 20;

  // One row of the directed sequence; typed rows carry their own result
  typedef struct {
    bit                     reprog;
    logic [SAMPLE_BITS-1:0] head;
    logic [SAMPLE_BITS-1:0] rim;
    logic [TIME_BITS-1:0]   stamp;
    bit                     typed;
    hit_kind_t              kind;
    logic [SAMPLE_BITS-1:0] pk_head;
    logic [SAMPLE_BITS-1:0] pk_rim;
  } pad_row_t;

  localparam cfg_t DIRECTED_SET = '{
    low_threshold_head: 200, low_threshold_rim: 300,
    high_threshold_head: 1000, high_threshold_rim: 1200,
    retrigger_time: 50, scan_time: 10, crosstalk_time: 30
  };

  pad_row_t dir_rows [N_DIRECTED] = '{
    // reset settings: every level opens, zero window closes on the next item
    '{0,    0,    0, 32'h0000_0005, 1, HIT_NONE,    0,    0},
    '{0, 4095,    0, 32'h0000_0005, 1, HIT_HEAD, 4095,    0},
    // timestamp just behind the hold-off reference (after wrap) reads as negative
    '{0,    0, 4095, 32'hFFFF_FFFF, 1, HIT_NONE,    0,    0},
    '{0, 4095, 4095, 32'h0000_0006, 1, HIT_NONE,    0,    0},
    '{0,    0,    0, 32'h0000_0006, 1, HIT_RIM,  4095, 4095},
    // directed thresholds and times from here on
    '{1,  199,  299, 32'd1000,      1, HIT_NONE,    0,    0},
    '{0,  200,    0, 32'd1001,      1, HIT_NONE,    0,    0},
    '{0,  900,   50, 32'd1005,      0, HIT_NONE,    0,    0},
    '{0, 1000,  100, 32'd1011,      0, HIT_NONE,    0,    0},
    // rim still inside its crosstalk hold-off
    '{0, 4095, 4095, 32'd1040,      0, HIT_NONE,    0,    0},
    '{0,    0,  300, 32'd1061,      0, HIT_NONE,    0,    0},
    '{0,    0,  300, 32'd1091,      0, HIT_NONE,    0,    0},
    // head valid but short of the margin, rim invalid: peaks without a winner
    '{0, 1150, 1100, 32'd1101,      0, HIT_NONE,    0,    0},
    '{0, 1300,    0, 32'd1102,      0, HIT_NONE,    0,    0},
    '{0,    0, 1250, 32'd1103,      0, HIT_NONE,    0,    0},
    '{0,    0,    0, 32'd1112,      0, HIT_NONE,    0,    0},
    '{0,  400,    0, 32'd1150,      0, HIT_NONE,    0,    0},
    '{0,  400,    0, 32'd1192,      0, HIT_NONE,    0,    0},
    // neither peak high enough: group dropped
    '{0,  500,  500, 32'd1202,      0, HIT_NONE,    0,    0},
    '{0, 2000, 2000, 32'h8000_1000, 1, HIT_NONE,    0,    0}
  };

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_wr_en = 1'b0;
  cfg_index_t cfg_index = CFG_LOW_HEAD;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Typed expectation travelling alongside the payload
  bit        in_typed = 1'b0;
  out_item_t in_typed_hit = '0;

  // Stimulus controls shared with the receiver
  bit gap_on = 1'b1;
  bit stall_on = 1'b1;
  bit hold_long_req = 1'b0;

  // Predictor state
  cfg_t                   cfg_now = '0;
  logic                   pad_open = 1'b0;
  logic [TIME_BITS-1:0]   open_stamp = '0;
  logic [SAMPLE_BITS-1:0] hold_head = '0;
  logic [SAMPLE_BITS-1:0] hold_rim = '0;
  logic [TIME_BITS-1:0]   head_blk = '0;
  logic [TIME_BITS-1:0]   rim_blk = '0;

  out_item_t pending_hits [$];
  int n_errors = 0;
  int n_transfers = 0;
  int n_head_hits = 0;
  int n_rim_hits = 0;
  int n_unclaimed = 0;
  int idle_cycles = 0;

  drum_pad_hit_detector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A pad may open a group once its hold-off has run out (signed distance)
  function automatic logic pad_clear(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] blk);
    logic [TIME_BITS-1:0] span;
    span = now - blk;
    return !span[TIME_BITS-1] && (span >= TIME_BITS'(cfg_now.retrigger_time));
  endfunction

  // Advance the detector by one sample pair and return its result
  function automatic out_item_t predict_hit(in_item_t s);
    out_item_t r;
    logic [TIME_BITS-1:0] elapsed;
    logic head_ok;
    logic rim_ok;
    r = '0;
    r.hit_kind = HIT_NONE;
    r.hit_time = s.time_now;
    if (!pad_open) begin
      if ((s.sample_head >= cfg_now.low_threshold_head && pad_clear(s.time_now, head_blk)) ||
          (s.sample_rim >= cfg_now.low_threshold_rim && pad_clear(s.time_now, rim_blk))) begin
        pad_open = 1'b1;
        open_stamp = s.time_now;
        hold_head = s.sample_head;
        hold_rim = s.sample_rim;
      end
    end else begin
      if (s.sample_head > hold_head) hold_head = s.sample_head;
      if (s.sample_rim > hold_rim) hold_rim = s.sample_rim;
      elapsed = s.time_now - open_stamp;
      if (elapsed >= TIME_BITS'(cfg_now.scan_time)) begin
        head_ok = hold_head >= cfg_now.high_threshold_head;
        rim_ok = hold_rim >= cfg_now.high_threshold_rim;
        if (head_ok || rim_ok) begin
          if (head_ok && ({1'b0, hold_head} > {1'b0, hold_rim} + HEAD_LEAD)) begin
            r.hit_kind = HIT_HEAD;
            head_blk = s.time_now;
            rim_blk = s.time_now + TIME_BITS'(cfg_now.crosstalk_time);
            n_head_hits++;
          end else if (rim_ok) begin
            r.hit_kind = HIT_RIM;
            rim_blk = s.time_now;
            head_blk = s.time_now + TIME_BITS'(cfg_now.crosstalk_time);
            n_rim_hits++;
          end else begin
            n_unclaimed++;
          end
          r.peak_head_out = hold_head;
          r.peak_rim_out = hold_rim;
        end
        pad_open = 1'b0;
        hold_head = '0;
        hold_rim = '0;
      end
    end
    return r;
  endfunction

  task automatic check_field(string fname, logic [TIME_BITS-1:0] want, logic [TIME_BITS-1:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fname, want, got);
    end
  endtask

  // Offer one item and hold it until the block takes it; maybe idle afterwards
  task automatic drive_item(in_item_t it, bit typed, out_item_t typed_hit);
    in_valid <= 1'b1;
    in_data <= it;
    in_typed <= typed;
    in_typed_hit <= typed_hit;
    do @(posedge clk); while (in_stall);
    if (gap_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(cfg_t c);
    write_reg(CFG_LOW_HEAD, CFG_DATA_BITS'(c.low_threshold_head));
    write_reg(CFG_LOW_RIM, CFG_DATA_BITS'(c.low_threshold_rim));
    write_reg(CFG_HIGH_HEAD, CFG_DATA_BITS'(c.high_threshold_head));
    write_reg(CFG_HIGH_RIM, CFG_DATA_BITS'(c.high_threshold_rim));
    write_reg(CFG_RETRIG, CFG_DATA_BITS'(c.retrigger_time));
    write_reg(CFG_SCAN, CFG_DATA_BITS'(c.scan_time));
    write_reg(CFG_XTALK, CFG_DATA_BITS'(c.crosstalk_time));
    cfg_wr_en <= 1'b0;
    cfg_now = c;
  endtask

  // Drop valid and wait until every result has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_hits.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Check results against the oldest expectation, record accepted items
  always @(posedge clk) begin : track
    out_item_t want;
    out_item_t pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_hits.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result: expected none, actual kind %0d time 0x%0h",
                   $time, out_data.hit_kind, out_data.hit_time);
        end else begin
          want = pending_hits.pop_front();
          check_field("hit_kind", TIME_BITS'(want.hit_kind), TIME_BITS'(out_data.hit_kind));
          check_field("peak_head_out", TIME_BITS'(want.peak_head_out),
                      TIME_BITS'(out_data.peak_head_out));
          check_field("peak_rim_out", TIME_BITS'(want.peak_rim_out),
                      TIME_BITS'(out_data.peak_rim_out));
          check_field("hit_time", want.hit_time, out_data.hit_time);
        end
      end
      if (in_valid && !in_stall) begin
        pred = predict_hit(in_data);
        pending_hits.push_back(in_typed ? in_typed_hit : pred);
        n_transfers++;
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL drum_pad_hit_detector");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_long_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (stall_on ? $urandom_range(1, 20) : 1) @(posedge clk);
      end
    end
  end

  initial begin
    in_item_t    it;
    out_item_t   row_hit;
    cfg_t        set;
    int unsigned step_max;
    int unsigned h_val;
    int unsigned r_val;
    int unsigned lo_h;
    int unsigned lo_r;
    logic [TIME_BITS-1:0] stamp;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sequence
    foreach (dir_rows[i]) begin
      if (dir_rows[i].reprog) begin
        wait_idle();
        apply_settings(DIRECTED_SET);
      end
      it.sample_head = dir_rows[i].head;
      it.sample_rim = dir_rows[i].rim;
      it.time_now = dir_rows[i].stamp;
      row_hit.hit_kind = dir_rows[i].kind;
      row_hit.peak_head_out = dir_rows[i].pk_head;
      row_hit.peak_rim_out = dir_rows[i].pk_rim;
      row_hit.hit_time = dir_rows[i].stamp;
      drive_item(it, dir_rows[i].typed, row_hit);
    end

    // Random phases, each under a register setting chosen by the phase number
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: set = '0;
        1: set = '1;
        2: begin
          set.low_threshold_head = 12'($urandom_range(20, 1500));
          set.low_threshold_rim = 12'($urandom_range(20, 1500));
          set.high_threshold_head = 12'($urandom_range(500, 3500));
          set.high_threshold_rim = 12'($urandom_range(500, 3500));
          set.retrigger_time = 20'($urandom_range(0, 300));
          set.scan_time = 16'($urandom_range(0, 60));
          set.crosstalk_time = 20'($urandom_range(0, 200));
        end
        default: begin
          set.low_threshold_head = 12'($urandom_range(0, 4095));
          set.low_threshold_rim = 12'($urandom_range(0, 4095));
          set.high_threshold_head = 12'($urandom_range(0, 4095));
          set.high_threshold_rim = 12'($urandom_range(0, 4095));
          set.retrigger_time = 20'($urandom_range(0, 20'hFFFFF));
          set.scan_time = 16'($urandom_range(0, 16'hFFFF));
          set.crosstalk_time = 20'($urandom_range(0, 20'hFFFFF));
        end
      endcase
      wait_idle();
      apply_settings(set);

      // Quiet phases near the end and in the middle; one phase under back-pressure
      gap_on = !(p == NUM_PHASES - 1 || p == 5);
      stall_on = gap_on;
      if (p == 2) begin
        gap_on = 1'b0;
        hold_long_req = 1'b1;
      end

      // Scale the timestamp step so that windows close and hold-offs expire
      step_max = 32'(set.scan_time) / 8 +
                 (32'(set.retrigger_time) + 32'(set.crosstalk_time)) / 32 + 3;
      lo_h = (set.low_threshold_head > 20) ? set.low_threshold_head - 20 : 0;
      lo_r = (set.low_threshold_rim > 20) ? set.low_threshold_rim - 20 : 0;
      if ($urandom_range(0, 1) == 0)
        stamp = $urandom();
      else
        stamp = 32'hFFFF_FFFF - $urandom_range(0, 30 * step_max);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            h_val = $urandom_range(0, 255);
            r_val = $urandom_range(0, 255);
          end
          3, 4, 5: begin
            h_val = $urandom_range(lo_h, 4095);
            r_val = $urandom_range(0, h_val);
          end
          6, 7: begin
            r_val = $urandom_range(lo_r, 4095);
            h_val = $urandom_range(0, r_val);
          end
          8: begin
            h_val = $urandom_range(lo_h, 4095);
            r_val = $urandom_range(lo_r, 4095);
          end
          default: begin
            h_val = $urandom_range(0, 4095);
            r_val = $urandom_range(0, 4095);
          end
        endcase
        // Occasional timestamp jump, otherwise a forward step
        if ($urandom_range(0, 63) == 0)
          stamp = $urandom();
        else
          stamp = stamp + $urandom_range(0, step_max);
        it.sample_head = 12'(h_val);
        it.sample_rim = 12'(r_val);
        it.time_now = stamp;
        drive_item(it, 1'b0, '0);
      end
    end

    wait_idle();
    $display("Run covered %0d transfers over %0d register settings and a directed sequence.",
             n_transfers, NUM_PHASES + 1);
    $display("Predicted %0d head hits, %0d rim hits and %0d valid groups without a winner.",
             n_head_hits, n_rim_hits, n_unclaimed);
    if (n_errors == 0)
      $display("PASS drum_pad_hit_detector");
    else
      $display("FAIL drum_pad_hit_detector");
    $finish;
  end

endmodule

[drum_pad_hit_detector.f]
hdl/dphd_pkg.sv
hdl/dphd_cfg.sv
hdl/dphd_core.sv
hdl/dphd_skid.sv
hdl/drum_pad_hit_detector.sv
hdl/dphd_checker.sv
tb/testbench.sv
